[rtl/sha256_pkg.sv]
// SHA-256 package: round constants, initial hash values and round functions.
// Used by sha256_round_unit, sha256_message_hash_core and sha256_digest_checker; depends on nothing.
package sha256_pkg;

   typedef logic [31:0] word_type;
   typedef logic [5:0]  round_idx_type;

   typedef struct packed {
      logic     start;
      logic     step;
      word_type wt;
   } round_ctl_type;

   localparam logic [255:0] INIT_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic word_type round_k(input round_idx_type t);
      word_type k;
      unique case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic word_type rotr(input word_type v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic word_type sched_sig0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sched_sig1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

[rtl/sha256_round_unit.sv]
// SHA-256 round datapath: working variables a..h and one round per step.
// Depends on sha256_pkg.
module sha256_round_unit (
   input  logic                          clock,
   input  sha256_pkg::round_ctl_type     ctl,
   input  logic [255:0]                  chain,
   input  sha256_pkg::round_idx_type     round,
   output logic [255:0]                  vars
);

   sha256_pkg::word_type v_ff [8];
   sha256_pkg::word_type v_in [8];
   sha256_pkg::word_type s1, ch, t1, s0, mj;

   always_comb begin
      s1 = sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
         ^ sha256_pkg::rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + sha256_pkg::round_k(round) + ctl.wt;
      s0 = sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
         ^ sha256_pkg::rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      for (int j = 0; j < 8; j++) v_in[j] = v_ff[j];
      if (ctl.start) begin
         for (int j = 0; j < 8; j++) v_in[j] = chain[255-32*j -: 32];
      end else if (ctl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + s0 + mj;
      end
      for (int j = 0; j < 8; j++) vars[255-32*j -: 32] = v_ff[j];
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 8; j++) v_ff[j] <= v_in[j];
   end

endmodule

[rtl/sha256_message_hash_core.sv]
// SHA-256 message hash top level: byte intake, padding, schedule memory, rounds.
// Depends on sha256_pkg and sha256_round_unit.
// Takes at most one message byte per word and returns the 256-bit digest after the
// word marked last. Bytes are absorbed into a 16-entry schedule memory; every 64th
// byte starts a compression of 64 rounds, each round a memory read of the schedule
// words (ST_RD), then the round and write-back (ST_RND); the input is held off for
// the whole block. After the word marked last the padding bytes enter at one per
// cycle between compressions, and one or two compressions follow; the ADD state
// adds into the chaining state and the OUT state loads the digest register. A new
// message is taken while a digest waits, and the core stalls before its own digest
// until the waiting one is accepted.
module sha256_message_hash_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_part0,
   output logic [63:0] rsp_digest_part1,
   output logic [63:0] rsp_digest_part2,
   output logic [63:0] rsp_digest_part3
);

   localparam logic [2:0] ST_IDLE = 3'd0, ST_PAD = 3'd1, ST_LOAD = 3'd2,
      ST_RD = 3'd3, ST_RND = 3'd4, ST_ADD = 3'd5, ST_OUT = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        fin_ff, fin_in;
   logic [3:0]  padk_ff, padk_in;
   logic [255:0] chain_ff, chain_in;
   logic [23:0] part_ff, part_in;

   sha256_pkg::word_type wmem [16];
   sha256_pkg::word_type rd15_ff, rd2_ff, rd7_ff, rd0_ff;
   logic        we;
   logic [3:0]  wa;
   sha256_pkg::word_type wd;

   logic        push;
   logic [7:0]  push_byte;
   logic [255:0] vars;
   sha256_pkg::round_ctl_type ctl;
   sha256_pkg::word_type wt;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      if (rnd_ff < 6'd16) wt = rd0_ff;
      else wt = sha256_pkg::sched_sig1(rd2_ff) + rd7_ff
         + sha256_pkg::sched_sig0(rd15_ff) + rd0_ff;
   end

   always_comb begin
      state_in = state_ff; bits_in = bits_ff; pos_in = pos_ff; rnd_in = rnd_ff;
      fin_in = fin_ff; padk_in = padk_ff; chain_in = chain_ff; part_in = part_ff;
      push = 1'b0; push_byte = '0;
      we = 1'b0; wa = '0; wd = '0;
      ctl = '{start: 1'b0, step: 1'b0, wt: wt};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_has_byte) begin
                  push = 1'b1; push_byte = req_data_byte;
                  bits_in = bits_ff + 64'd8;
               end
               fin_in = req_last;
               padk_in = '0;
               if (req_has_byte && pos_ff == 6'd63) state_in = ST_LOAD;
               else if (req_last) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            push = 1'b1;
            if (padk_ff == 4'd0) begin
               push_byte = 8'h80; padk_in = 4'd1;
            end else if (padk_ff == 4'd1) begin
               if (pos_ff == 6'd56) begin
                  push_byte = bits_ff[63:56]; padk_in = 4'd3;
               end else push_byte = 8'h00;
            end else begin
               push_byte = bits_ff[63 - 8*(padk_ff - 4'd2) -: 8];
               padk_in = padk_ff + 4'd1;
            end
            if (pos_ff == 6'd63) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ctl.start = 1'b1; rnd_in = '0; state_in = ST_RD;
         end
         ST_RD: state_in = ST_RND;
         ST_RND: begin
            ctl.step = 1'b1;
            if (rnd_ff >= 6'd16) begin
               we = 1'b1; wa = rnd_ff[3:0]; wd = wt;
            end
            rnd_in = rnd_ff + 6'd1;
            state_in = (rnd_ff == 6'd63) ? ST_ADD : ST_RD;
         end
         ST_ADD: begin
            for (int j = 0; j < 8; j++)
               chain_in[255-32*j -: 32] = chain_ff[255-32*j -: 32] + vars[255-32*j -: 32];
            if (!fin_ff) state_in = ST_IDLE;
            else if (padk_ff == 4'd10) state_in = ST_OUT;
            else state_in = ST_PAD;
         end
         ST_OUT: begin
            if (!rsp_valid) begin
               state_in = ST_IDLE; bits_in = '0; pos_in = '0; fin_in = 1'b0;
               chain_in = sha256_pkg::INIT_HASH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (push) begin
         unique case (pos_ff[1:0])
            2'd0: part_in = {push_byte, 16'h0};
            2'd1: part_in = {part_ff[23:16], push_byte, 8'h0};
            2'd2: part_in = {part_ff[23:8], push_byte};
            default: part_in = part_ff;
         endcase
         if (pos_ff[1:0] == 2'd3) begin
            we = 1'b1; wa = pos_ff[5:2]; wd = {part_ff, push_byte};
         end
         pos_in = pos_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) wmem[wa] <= wd;
      rd15_ff <= wmem[rnd_in[3:0] + 4'd1];
      rd2_ff  <= wmem[rnd_in[3:0] + 4'd14];
      rd7_ff  <= wmem[rnd_in[3:0] + 4'd9];
      rd0_ff  <= wmem[rnd_in[3:0]];
   end

   sha256_round_unit u_round (
      .clock (clock),
      .ctl   (ctl),
      .chain (chain_ff),
      .round (rnd_ff),
      .vars  (vars)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; bits_ff <= '0; pos_ff <= '0; rnd_ff <= '0;
         fin_ff <= 1'b0; padk_ff <= '0; chain_ff <= sha256_pkg::INIT_HASH;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; bits_ff <= bits_in; pos_ff <= pos_in;
         rnd_ff <= rnd_in; fin_ff <= fin_in; padk_ff <= padk_in;
         chain_ff <= chain_in;
         if (state_ff == ST_OUT && !rsp_valid) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
      part_ff <= part_in;
      if (state_ff == ST_OUT && !rsp_valid) begin
         rsp_digest_part0 <= chain_ff[255:192];
         rsp_digest_part1 <= chain_ff[191:128];
         rsp_digest_part2 <= chain_ff[127:64];
         rsp_digest_part3 <= chain_ff[63:0];
      end
   end

endmodule

[bench/sha256_digest_checker.sv]
// Digest checker for sha256_message_hash_core: watches both channels, hashes the bytes
// itself and compares every digest word with the oldest predicted digest.
// Depends on sha256_pkg for the initial hash values.
`timescale 1ns / 1ps
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_digest_part0,
   input  logic [63:0] rsp_digest_part1,
   input  logic [63:0] rsp_digest_part2,
   input  logic [63:0] rsp_digest_part3,
   output int          error_count,
   output int          digests_pending,
   output int          digests_seen
);

   localparam int PRED_DEPTH = 1024;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [31:0]  msg_block [16];
   logic [31:0]  hash_state [8];
   logic [63:0]  msg_bits;
   int           fill_pos;
   logic [255:0] pred_store [PRED_DEPTH];
   int           pred_wr;
   int           pred_rd;

   function automatic logic [31:0] ror(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, g, h, wt, t1, t2;
      w = msg_block;
      {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
      {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            wt = (ror(w[(t - 2) & 15], 17) ^ ror(w[(t - 2) & 15], 19) ^ (w[(t - 2) & 15] >> 10))
               + w[(t - 7) & 15]
               + (ror(w[(t - 15) & 15], 7) ^ ror(w[(t - 15) & 15], 18)
                  ^ (w[(t - 15) & 15] >> 3))
               + w[t & 15];
            w[t & 15] = wt;
         end
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[t] + wt;
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   task automatic absorb(input logic [7:0] b);
      msg_block[fill_pos / 4][8 * (3 - fill_pos % 4) +: 8] = b;
      fill_pos++;
      if (fill_pos == 64) begin
         compress();
         fill_pos = 0;
      end
   endtask

   task automatic start_message();
      for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::INIT_HASH[255 - 32 * i -: 32];
      msg_bits = '0;
      fill_pos = 0;
   endtask

   task automatic hash_word(input logic [7:0] b, input logic has_b, input logic fin);
      logic [63:0] len;
      if (has_b) begin
         absorb(b);
         msg_bits += 64'd8;
      end
      if (fin) begin
         len = msg_bits;
         absorb(8'h80);
         while (fill_pos != 56) absorb(8'h00);
         for (int k = 7; k >= 0; k--) absorb(len[8 * k +: 8]);
         pred_store[pred_wr % PRED_DEPTH] = {hash_state[0], hash_state[1], hash_state[2],
                                             hash_state[3], hash_state[4], hash_state[5],
                                             hash_state[6], hash_state[7]};
         pred_wr++;
         start_message();
      end
   endtask

   task automatic check_part(input int idx, input logic [63:0] exp_v, input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         error_count++;
         $display("%0t: digest_part%0d mismatch, expected %h, got %h", $time, idx, exp_v, act_v);
      end
   endtask

   assign digests_pending = pred_wr - pred_rd;

   always @(posedge clock) begin
      logic [255:0] exp_d;
      if (reset) begin
         error_count = 0;
         digests_seen = 0;
         pred_wr = 0;
         pred_rd = 0;
         start_message();
      end else begin
         if (req_valid && req_ready) hash_word(req_data_byte, req_has_byte, req_last);
         if (rsp_valid && rsp_ready) begin
            digests_seen++;
            if (pred_wr == pred_rd) begin
               error_count++;
               $display("%0t: digest with none expected, got %h %h %h %h", $time,
                        rsp_digest_part0, rsp_digest_part1, rsp_digest_part2,
                        rsp_digest_part3);
            end else begin
               exp_d = pred_store[pred_rd % PRED_DEPTH];
               pred_rd++;
               check_part(0, exp_d[255:192], rsp_digest_part0);
               check_part(1, exp_d[191:128], rsp_digest_part1);
               check_part(2, exp_d[127:64], rsp_digest_part2);
               check_part(3, exp_d[63:0], rsp_digest_part3);
            end
         end
      end
   end
endmodule

[bench/tb_sha256_message_hash_core.sv]
// Testbench top for sha256_message_hash_core: sends byte messages with random gaps
// and stalls; sha256_digest_checker predicts and compares every digest.
// Depends on sha256_pkg, the core and the checker.
`timescale 1ns / 1ps
module tb_sha256_message_hash_core;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_has_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_digest_part0, rsp_digest_part1, rsp_digest_part2, rsp_digest_part3;
   int          error_count, digests_pending, digests_seen;
   int          words_sent = 0;
   int          idle_cycles = 0;
   logic        stim_done = 1'b0;
   logic        long_hold = 1'b0;

   localparam int IDLE_LIMIT = 20000;

   sha256_message_hash_core dut (.*);

   sha256_digest_checker checker_i (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic send_word(input logic [7:0] b, input logic has_b, input logic fin);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (words_sent % 200 < 60) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_has_byte <= has_b;
      req_last <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_message(input int n_bytes, input int pattern, input logic empty_end);
      logic [7:0] b;
      for (int i = 0; i < n_bytes; i++) begin
         case (pattern)
            0: b = 8'h00;
            1: b = 8'hff;
            2: b = 8'h61 + 8'(i % 3);
            default: b = 8'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_word(b, 1'b1, !empty_end && i == n_bytes - 1);
      end
      if (empty_end || n_bytes == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_message(0, 3, 1'b1);
      send_message(3, 2, 1'b0);
      send_word(8'hab, 1'b0, 1'b0);
      send_message(1, 1, 1'b0);
      send_message(1, 0, 1'b0);
      send_message(55, 1, 1'b0);
      send_message(56, 0, 1'b1);
      send_message(64, 3, 1'b0);
      while (words_sent < 950) begin
         len = $urandom_range(0, 4) == 0 ? $urandom_range(55, 130) : $urandom_range(0, 20);
         send_message(len, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 3,
                      $urandom_range(0, 3) == 0);
      end
      req_valid <= 1'b0;
      stim_done <= 1'b1;
   end

   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (words_sent > 300 && !long_hold) begin
            long_hold = 1'b1;
            rsp_ready <= 1'b0;
            repeat (3000) @(posedge clock);
         end
         stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
         if (words_sent % 300 < 80) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(negedge reset);
      fork
         begin
            wait (stim_done && digests_pending == 0);
            repeat (400) @(posedge clock);
            $display("Sent %0d words and checked %0d digests, including empty, padding",
                     words_sent, digests_seen);
            $display("boundary and multi-block messages under random gaps and stalls.");
            if (error_count == 0) begin
               $display("Verification passed");
            end else begin
               $display("Verification failed");
            end
         end
         begin
            wait (idle_cycles >= IDLE_LIMIT);
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Verification failed");
         end
      join_any
      $finish;
   end
endmodule
